// File: sv/assert_macros.svh
// assertion macros used by the checker file
// expects signals named clock and reset in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TPKH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define TPKH_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/tpkh_pkg.sv
// types, constants and the key scramble function of the tracker pad block
// used by the core and its checker, depends on nothing

package tpkh_pkg;

   typedef enum logic [1:0] {
      REQ_MAGIC = 2'd0,
      REQ_KEY   = 2'd1,
      REQ_POLL  = 2'd2,
      REQ_CTRL  = 2'd3
   } req_kind_type;

   localparam logic [1:0] CSR_INVERT_X = 2'd0;
   localparam logic [1:0] CSR_INVERT_Y = 2'd1;
   localparam logic [1:0] CSR_INVERT_Z = 2'd2;
   localparam logic [1:0] CSR_Z_LIMIT  = 2'd3;

   localparam logic [2:0] CTRL_PEDAL   = 3'd0;
   localparam logic [2:0] CTRL_LEFT_X  = 3'd1;
   localparam logic [2:0] CTRL_LEFT_Y  = 3'd2;
   localparam logic [2:0] CTRL_LEFT_Z  = 3'd3;
   localparam logic [2:0] CTRL_RIGHT_X = 3'd4;
   localparam logic [2:0] CTRL_RIGHT_Y = 3'd5;
   localparam logic [2:0] CTRL_RIGHT_Z = 3'd6;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USED_W = 75;

   localparam logic [63:0] MAGIC_WORD     = 64'h6B61_7274_656D_6147;
   localparam logic [3:0]  MAGIC_LEN      = 4'd8;
   localparam logic [3:0]  KEY_LEN        = 4'd2;
   localparam logic [7:0]  KEY_SEED_MARK  = 8'h45;
   localparam logic [11:0] AXIS_FULL      = 12'd2047;
   localparam logic [11:0] Z_LIMIT_RESET  = 12'd4095;
   localparam logic [16:0] PEDAL_ON_LEVEL = 17'h08000;
   localparam logic [29:0] ROUND_HALF     = 30'h0000_8000;

   function automatic logic [23:0] scramble(input logic [23:0] k);
      logic [23:0] r;
      r  = (k << 2)  & 24'hFC0000;
      r  = r | ((k << 17) & 24'h020000);
      r  = r ^ ((k << 16) & 24'hFE0000);
      r  = r | (k & 24'h010000);
      r  = r | ((k >> 9) & 24'h007F7F);
      r  = r | ((k << 7) & 24'h008080);
      return r;
   endfunction

endpackage

// File: sv/tracker_pad_key_handshake_core.sv
// tracker pad with key handshake: request register, one pass of update logic, result register
// depends on tpkh_pkg
//
//   channel  | ports                | contents
//   request  | req_tvalid/tready    | tuser req_type, tdata length, payload, index, value
//   response | rsp_tvalid/tready    | tuser is_magic, tdata key bits, pedal, six axes
//   csr      | csr_valid/ready      | csr_index, csr_data
//
// one request per cycle unless a poll in the input register waits on a full result register; a poll
// answer is written to the result register as the poll leaves the input register and holds there until taken
// only a poll waits on a full result register, other requests pass it
// synchronous active-high reset re-arms the identification reply, clears key and axes

module tracker_pad_key_handshake_core import tpkh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // payload_length[3:0], payload[67:4], control_index[70:68], control_value[87:71]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // key_bits[5:0], button[6], left_x[17:7], left_y[28:18], left_z[40:29],
   // right_x[51:41], right_y[62:52], right_z[74:63], zero[79:75]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // is_magic[0]
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [11:0]           csr_data
);

   logic                  in_valid_ff;
   req_kind_type          in_kind_ff;
   logic [3:0]            in_len_ff;
   logic [63:0]           in_payload_ff;
   logic [2:0]            in_index_ff;
   logic [16:0]           in_value_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_magic_ff;

   logic                  inv_x_ff, inv_y_ff, inv_z_ff;
   logic [11:0]           z_limit_ff;

   logic                  magic_pending_ff, magic_pending_in;
   logic [23:0]           key_ff, key_in;
   logic                  pedal_ff, pedal_in;
   logic [10:0]           xy_ff [4];
   logic [10:0]           xy_in [4];
   logic [11:0]           z_ff [2];
   logic [11:0]           z_in [2];

   logic                  req_take;
   logic                  in_advance;
   logic                  is_poll;
   logic [7:0]            key_b0, key_b1;
   logic [23:0]           key_seed, key_new;
   logic                  axis_is_z;
   logic                  axis_invert;
   logic [11:0]           axis_full;
   logic [28:0]           axis_prod;
   logic [29:0]           axis_round;
   logic [13:0]           axis_scaled;
   logic [11:0]           axis_clamped;
   logic [11:0]           axis_value;

   assign is_poll    = (in_kind_ff == REQ_POLL);
   assign in_advance = in_valid_ff && (!is_poll || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || in_advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_magic_ff;

   // key report
   assign key_b0   = in_payload_ff[7:0];
   assign key_b1   = in_payload_ff[15:8];
   assign key_seed = (key_b0 == KEY_SEED_MARK) ? {key_b1, 16'h0000} : key_ff;
   assign key_new  = (key_seed[23:16] == key_b1) ? scramble(key_seed) : key_seed;

   // axis scaling with round half up and clamp
   assign axis_is_z    = (in_index_ff == CTRL_LEFT_Z) || (in_index_ff == CTRL_RIGHT_Z);
   assign axis_full    = axis_is_z ? z_limit_ff : AXIS_FULL;
   assign axis_prod    = {12'd0, in_value_ff} * {17'd0, axis_full};
   assign axis_round   = {1'b0, axis_prod} + ROUND_HALF;
   assign axis_scaled  = axis_round[29:16];
   assign axis_clamped = (axis_scaled > {2'b00, axis_full}) ? axis_full : axis_scaled[11:0];
   assign axis_value   = axis_invert ? (axis_full - axis_clamped) : axis_clamped;

   always_comb begin
      unique case (in_index_ff)
         CTRL_LEFT_X, CTRL_RIGHT_X: axis_invert = inv_x_ff;
         CTRL_LEFT_Y, CTRL_RIGHT_Y: axis_invert = inv_y_ff;
         CTRL_LEFT_Z, CTRL_RIGHT_Z: axis_invert = inv_z_ff;
         default:                   axis_invert = 1'b0;
      endcase
   end

   always_comb begin
      magic_pending_in = magic_pending_ff;
      key_in           = key_ff;
      pedal_in         = pedal_ff;
      xy_in            = xy_ff;
      z_in             = z_ff;
      if (in_advance) begin
         unique case (in_kind_ff)
            REQ_MAGIC: begin
               if (in_len_ff == MAGIC_LEN && in_payload_ff == MAGIC_WORD) begin
                  magic_pending_in = 1'b1;
                  key_in           = '0;
               end
            end
            REQ_KEY: begin
               if (in_len_ff == KEY_LEN) begin
                  key_in = key_new;
               end
            end
            REQ_POLL: begin
               magic_pending_in = 1'b0;
            end
            REQ_CTRL: begin
               unique case (in_index_ff)
                  CTRL_PEDAL:   pedal_in = (in_value_ff >= PEDAL_ON_LEVEL);
                  CTRL_LEFT_X:  xy_in[0] = axis_value[10:0];
                  CTRL_LEFT_Y:  xy_in[1] = axis_value[10:0];
                  CTRL_RIGHT_X: xy_in[2] = axis_value[10:0];
                  CTRL_RIGHT_Y: xy_in[3] = axis_value[10:0];
                  CTRL_LEFT_Z:  z_in[0]  = axis_value;
                  CTRL_RIGHT_Z: z_in[1]  = axis_value;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (in_advance && is_poll) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         inv_x_ff         <= 1'b0;
         inv_y_ff         <= 1'b0;
         inv_z_ff         <= 1'b0;
         z_limit_ff       <= Z_LIMIT_RESET;
         magic_pending_ff <= 1'b1;
         key_ff           <= '0;
         pedal_ff         <= 1'b0;
         xy_ff            <= '{default: '0};
         z_ff             <= '{default: '0};
      end else begin
         in_valid_ff      <= req_take || (in_valid_ff && !in_advance);
         rsp_valid_ff     <= rsp_valid_in;
         magic_pending_ff <= magic_pending_in;
         key_ff           <= key_in;
         pedal_ff         <= pedal_in;
         xy_ff            <= xy_in;
         z_ff             <= z_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_INVERT_X: inv_x_ff   <= csr_data[0];
               CSR_INVERT_Y: inv_y_ff   <= csr_data[0];
               CSR_INVERT_Z: inv_z_ff   <= csr_data[0];
               CSR_Z_LIMIT:  z_limit_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff    <= req_kind_type'(req_tuser);
         in_len_ff     <= req_tdata[3:0];
         in_payload_ff <= req_tdata[67:4];
         in_index_ff   <= req_tdata[70:68];
         in_value_ff   <= req_tdata[87:71];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (in_advance && is_poll) begin
         rsp_magic_ff <= magic_pending_ff;
         if (magic_pending_ff) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff <= {{(RSP_DATA_W-RSP_USED_W){1'b0}}, z_ff[1], xy_ff[3], xy_ff[2],
                            z_ff[0], xy_ff[1], xy_ff[0], pedal_ff, key_ff[21:16]};
         end
      end
   end

endmodule

// File: sv/tpkh_checker.sv
// port-level checker for the tracker pad core, with its bind statement
// depends on tpkh_pkg and assert_macros.svh

`include "assert_macros.svh"

module tpkh_checker import tpkh_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // identification reply carries nothing else
   `TPKH_ASSERT(magic_reply_empty, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "magic reply with data")

   // response register is empty right after reset
   `TPKH_ASSERT_ALWAYS(reset_clears_rsp, reset |=> !rsp_tvalid, "response valid after reset")

   // stalled response holds
   `TPKH_ASSERT(rsp_hold_valid, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response dropped")

   `TPKH_ASSERT(rsp_hold_data, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "response changed")

endmodule

bind tracker_pad_key_handshake_core tpkh_checker u_tpkh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
